/* hw/rtl/tkls_pkg.sv */
// ----------------------------------------------------------------------------
// tkls_pkg
// Shared types and constants for the lowest-score keeper: entry layout,
// request kinds and the command/status bundles between control and datapath.
// ----------------------------------------------------------------------------
package tkls_pkg;

  localparam int DEPTH_DEF   = 64;

  localparam int SCORE_W     = 32;
  localparam int BLOCK_W     = 16;
  localparam int CELL_W      = 12;
  localparam int ENTRY_W     = SCORE_W + BLOCK_W + CELL_W;
  localparam int TDATA_W     = ((ENTRY_W + 7) / 8) * 8;
  localparam int MODE_W      = 2;
  localparam int OUT_TUSER_W = 1;

  // request kinds carried on in_tuser
  localparam logic [MODE_W-1:0] MODE_OFFER = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  // score sits in the low bits, so the packed entry matches tdata[ENTRY_W-1:0]
  typedef struct packed {
    logic [CELL_W-1:0]  cell_idx;
    logic [BLOCK_W-1:0] block;
    logic [SCORE_W-1:0] score;
  } entry_t;

  typedef struct packed {
    logic latch;       // capture the incoming candidate
    logic append;      // write incoming candidate to next free slot
    logic scan_start;  // begin a pass over the occupied slots
    logic scan_min;    // pass looks for next-lowest key (else for worst)
    logic apply;       // overwrite worst slot with latched candidate
    logic clear;       // empty the store
    logic rank_clr;    // start of a readout
    logic emit;        // load best entry into the output register
    logic emit_empty;  // load the empty-store result
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic scan_done;
    logic cand_lower;  // latched candidate beats the worst entry
    logic last_rank;   // entry being emitted is the last of the readout
    logic out_free;
  } sts_t;

endpackage

/* hw/rtl/tkls_dp.sv */
// ----------------------------------------------------------------------------
// tkls_dp
// Datapath: entry memory, fill count, scan pipeline with compare stage,
// readout rank/previous-key tracking and the output register.
// ----------------------------------------------------------------------------
module tkls_dp #(
  parameter int DEPTH = tkls_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tkls_pkg::cmd_t                cmd,
  output tkls_pkg::sts_t                sts,
  input  logic [tkls_pkg::TDATA_W-1:0]  in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [tkls_pkg::TDATA_W-1:0]  out_tdata,
  output logic                          out_tlast,
  output logic [tkls_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import tkls_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t            mem [DEPTH];
  entry_t            in_entry;
  entry_t            cand_r;
  entry_t            rd_data_r;
  entry_t            best_r, best_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic              best_vld_r, best_vld_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [CNT_W-1:0]  fill_m1;
  logic [IDX_W-1:0]  scan_r, scan_nxt;
  logic [IDX_W-1:0]  scan_lim;
  logic              scan_act_r, scan_act_nxt;
  logic              scan_min_r;
  logic              rd_vld_r;
  logic              rd_last_r;
  logic [IDX_W-1:0]  rd_idx_r;
  logic [SCORE_W-1:0] prev_score_r;
  logic [IDX_W-1:0]  prev_idx_r;
  logic              prev_vld_r;
  logic [CNT_W-1:0]  rank_r;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;
  logic              eligible;
  logic              take;
  logic              out_vld_r, out_vld_nxt;
  entry_t            out_entry_r;
  logic              out_last_r;
  logic              out_ev_r;

  assign in_entry = entry_t'(in_tdata[ENTRY_W-1:0]);
  assign fill_m1  = fill_r - CNT_W'(1);
  assign scan_lim = fill_m1[IDX_W-1:0];

  // write port
  always_comb begin
    wr_en   = cmd.append || cmd.apply;
    wr_addr = cmd.apply ? best_idx_r : fill_r[IDX_W-1:0];
    wr_data = cmd.apply ? cand_r : in_entry;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[scan_r];
  end

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.clear) begin
      fill_nxt = '0;
    end else if (cmd.append) begin
      fill_nxt = fill_r + CNT_W'(1);
    end
  end

  // read issue: one slot per cycle, 0 .. fill-1
  always_comb begin
    scan_nxt     = scan_r;
    scan_act_nxt = scan_act_r;
    if (cmd.scan_start) begin
      scan_nxt     = '0;
      scan_act_nxt = 1'b1;
    end else if (scan_act_r) begin
      if (scan_r == scan_lim) begin
        scan_act_nxt = 1'b0;
      end else begin
        scan_nxt = scan_r + IDX_W'(1);
      end
    end
  end

  // compare stage; slots arrive in ascending order so strict compares keep
  // the earliest slot on ties
  always_comb begin
    eligible = !prev_vld_r || (rd_data_r.score > prev_score_r) ||
               ((rd_data_r.score == prev_score_r) && (rd_idx_r > prev_idx_r));
    if (scan_min_r) begin
      take = eligible && (!best_vld_r || (rd_data_r.score < best_r.score));
    end else begin
      take = !best_vld_r || (rd_data_r.score > best_r.score);
    end
    best_nxt     = best_r;
    best_idx_nxt = best_idx_r;
    best_vld_nxt = best_vld_r;
    if (cmd.scan_start) begin
      best_vld_nxt = 1'b0;
    end else if (rd_vld_r && take) begin
      best_nxt     = rd_data_r;
      best_idx_nxt = rd_idx_r;
      best_vld_nxt = 1'b1;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (cmd.emit || cmd.emit_empty) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      scan_act_r <= 1'b0;
      rd_vld_r   <= 1'b0;
      best_vld_r <= 1'b0;
      prev_vld_r <= 1'b0;
      rank_r     <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      fill_r     <= fill_nxt;
      scan_act_r <= scan_act_nxt;
      rd_vld_r   <= scan_act_r;
      best_vld_r <= best_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      if (cmd.rank_clr) begin
        prev_vld_r <= 1'b0;
        rank_r     <= '0;
      end else if (cmd.emit) begin
        prev_vld_r <= 1'b1;
        rank_r     <= rank_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_r     <= scan_nxt;
    rd_idx_r   <= scan_r;
    rd_last_r  <= (scan_r == scan_lim);
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    if (cmd.scan_start) begin
      scan_min_r <= cmd.scan_min;
    end
    if (cmd.latch) begin
      cand_r <= in_entry;
    end
    if (cmd.emit) begin
      prev_score_r <= best_r.score;
      prev_idx_r   <= best_idx_r;
      out_entry_r  <= best_r;
      out_last_r   <= sts.last_rank;
      out_ev_r     <= 1'b1;
    end else if (cmd.emit_empty) begin
      out_entry_r  <= '0;
      out_last_r   <= 1'b1;
      out_ev_r     <= 1'b0;
    end
  end

  always_comb begin
    sts.full       = (fill_r == CNT_W'(DEPTH));
    sts.empty      = (fill_r == '0);
    sts.scan_done  = rd_vld_r && rd_last_r;
    sts.cand_lower = cand_r.score < best_r.score;
    sts.last_rank  = (rank_r == fill_m1);
    sts.out_free   = !out_vld_r || out_tready;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(TDATA_W - ENTRY_W){1'b0}}, out_entry_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ev_r;

endmodule

/* hw/rtl/tkls_ctrl.sv */
// ----------------------------------------------------------------------------
// tkls_ctrl
// Control state machine: decodes requests, sequences worst-entry and
// next-lowest scans, and paces readout results into the output register.
// ----------------------------------------------------------------------------
module tkls_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [tkls_pkg::MODE_W-1:0] in_tuser,
  input  tkls_pkg::sts_t              sts,
  output tkls_pkg::cmd_t              cmd
);
  import tkls_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_APPLY = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_EMPTY = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       rdout_r, rdout_nxt;

  always_comb begin
    state_nxt = state_r;
    rdout_nxt = rdout_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          unique case (in_tuser)
            MODE_OFFER: begin
              cmd.latch = 1'b1;
              if (!sts.full) begin
                cmd.append = 1'b1;
              end else begin
                cmd.scan_start = 1'b1;
                rdout_nxt      = 1'b0;
                state_nxt      = S_SCAN;
              end
            end
            MODE_READ: begin
              if (sts.empty) begin
                state_nxt = S_EMPTY;
              end else begin
                cmd.rank_clr   = 1'b1;
                cmd.scan_start = 1'b1;
                cmd.scan_min   = 1'b1;
                rdout_nxt      = 1'b1;
                state_nxt      = S_SCAN;
              end
            end
            MODE_CLEAR: cmd.clear = 1'b1;
            default: ;  // unused kind: dropped
          endcase
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = rdout_r ? S_EMIT : S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply = sts.cand_lower;
        state_nxt = S_IDLE;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last_rank) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.scan_start = 1'b1;
            cmd.scan_min   = 1'b1;
            state_nxt      = S_SCAN;
          end
        end
      end
      S_EMPTY: begin
        if (sts.out_free) begin
          cmd.emit_empty = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rdout_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rdout_r <= rdout_nxt;
    end
  end

endmodule

/* hw/rtl/top_k_lowest_score_keeper_core.sv */
// ----------------------------------------------------------------------------
// top_k_lowest_score_keeper_core
// Keeps the DEPTH lowest-scoring candidates of a stream; reads them out in
// ascending score order (ties in slot order) and clears on request.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)          | tuser        | tlast
//  in_     | in  | score, block_index, cell    | mode         | -
//  out_    | out | kept_score, kept_block,cell | entry_valid  | last_entry
//
//  An offer to a full store scans with one memory read per slot to find the worst
//  entry, then writes over it if the candidate scores lower. A readout makes one
//  full scan over the single read port per result.
//  Synchronous active-low reset empties the store; entries are not cleared.
//  A stalled out_tready holds the pending result and the request sequence.
// ----------------------------------------------------------------------------
module top_k_lowest_score_keeper_core #(
  parameter int DEPTH = tkls_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [tkls_pkg::TDATA_W-1:0]      in_tdata,   // score, block_index, cell_index
  input  logic [tkls_pkg::MODE_W-1:0]       in_tuser,   // mode
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [tkls_pkg::TDATA_W-1:0]      out_tdata,  // kept_score, kept_block, kept_cell
  output logic                              out_tlast,
  output logic [tkls_pkg::OUT_TUSER_W-1:0]  out_tuser   // entry_valid
);
  import tkls_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tkls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  tkls_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

/* hw/rtl/tkls_chk.sv */
// ----------------------------------------------------------------------------
// tkls_chk
// Port-level checker for the lowest-score keeper, bound to the top level.
// ----------------------------------------------------------------------------
module tkls_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [tkls_pkg::MODE_W-1:0]       in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [tkls_pkg::TDATA_W-1:0]      out_tdata,
  input logic                              out_tlast,
  input logic [tkls_pkg::OUT_TUSER_W-1:0]  out_tuser
);
  import tkls_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // nothing comes out of reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // empty-store result is a single, zero, final transfer
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == '0) |-> out_tlast && (out_tdata == '0))
    else $error("empty result malformed");

  // input ready drops right after an accepted readout request
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == MODE_READ) |=> !in_tready)
    else $error("input ready right after readout request");

endmodule

bind top_k_lowest_score_keeper_core tkls_chk u_tkls_chk (.*);
